// ===== rtl/mavgw_pkg.sv =====
package mavgw_pkg;

	// fixed widths of the register and count fields
	localparam int unsigned COUNT_BITS = 5;
	localparam logic [COUNT_BITS-1:0] LEN_RESET = 5'd15;

	// input kinds carried on s_tuser
	localparam logic ACTION_SAMPLE = 1'b0;
	localparam logic ACTION_CLEAR  = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic clear;
		logic write;
		logic sum_start;
		logic sum_step;
		logic div_start;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic sum_done;
		logic div_done;
	} dp_sts_t;

endpackage

// ===== rtl/mavgw_datapath.sv =====
module mavgw_datapath
	import mavgw_pkg::*;
#(
	parameter int unsigned MAX_WINDOW  = 16,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_cmd_t                       cmd,
	output dp_sts_t                       sts,
	input  logic                          cfg_wen,
	input  logic [COUNT_BITS-1:0]         cfg_wdata,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic signed [SAMPLE_BITS-1:0] average,
	output logic [COUNT_BITS-1:0]         valid_count
);

	localparam int unsigned PW    = $clog2(MAX_WINDOW);
	localparam int unsigned CMP_W = ((PW > COUNT_BITS) ? PW : COUNT_BITS) + 1;
	localparam int unsigned SW    = SAMPLE_BITS + COUNT_BITS;
	localparam int unsigned DCW   = $clog2(SW + 1);

	logic [COUNT_BITS-1:0]  len_q;
	logic [COUNT_BITS-1:0]  eff_len;
	logic [PW-1:0]          pos_q;
	logic                   full_q;
	logic [COUNT_BITS-1:0]  cnt_q;
	logic [CMP_W-1:0]       pos_inc;
	logic                   wrap;

	logic [SAMPLE_BITS-1:0] mem_q [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] rd_data_q;
	logic                   rd_vld_q;
	logic [COUNT_BITS-1:0]  idx_q;
	logic                   rd_en;
	logic signed [SW-1:0]   acc_q;
	logic signed [SW-1:0]   rd_ext;

	logic                   neg_q;
	logic [SW-1:0]          quo_q;
	logic [COUNT_BITS-1:0]  rem_q;
	logic [DCW-1:0]         dcnt_q;
	logic [COUNT_BITS:0]    rem_shift;
	logic                   rem_ge;
	logic [SW-1:0]          quo_signed;

	logic signed [SAMPLE_BITS-1:0] avg_q;
	logic [COUNT_BITS-1:0]         vcnt_q;

	// effective window length: zero means one, saturate at the store depth
	always_comb begin
		if (len_q == '0) begin
			eff_len = COUNT_BITS'(1);
		end else if (CMP_W'(len_q) > CMP_W'(MAX_WINDOW)) begin
			eff_len = COUNT_BITS'(MAX_WINDOW);
		end else begin
			eff_len = len_q;
		end
	end

	// next write position and wrap detect
	assign pos_inc = CMP_W'(pos_q) + CMP_W'(1);
	assign wrap    = (pos_inc >= CMP_W'(eff_len));

	// serial read of the window
	assign rd_en  = cmd.sum_step && (idx_q < cnt_q);
	assign rd_ext = {{(SW-SAMPLE_BITS){rd_data_q[SAMPLE_BITS-1]}}, rd_data_q};

	// restoring divide step on the magnitude
	assign rem_shift = {rem_q, quo_q[SW-1]};
	assign rem_ge    = (rem_shift >= {1'b0, cnt_q});

	assign quo_signed = neg_q ? (~quo_q + SW'(1)) : quo_q;

	// window store, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem_q[pos_q] <= sample;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[PW'(idx_q)];
		end
	end

	// window state, length register and sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= LEN_RESET;
			pos_q    <= '0;
			full_q   <= 1'b0;
			cnt_q    <= '0;
			idx_q    <= '0;
			rd_vld_q <= 1'b0;
			dcnt_q   <= '0;
		end else begin
			if (cfg_wen) begin
				len_q  <= cfg_wdata;
				pos_q  <= '0;
				full_q <= 1'b0;
			end else if (cmd.clear) begin
				pos_q  <= '0;
				full_q <= 1'b0;
			end else if (cmd.write) begin
				if (wrap) begin
					pos_q  <= '0;
					full_q <= 1'b1;
					cnt_q  <= eff_len;
				end else begin
					pos_q <= PW'(pos_inc);
					cnt_q <= full_q ? eff_len : COUNT_BITS'(pos_inc);
				end
			end

			if (cmd.sum_start) begin
				idx_q    <= '0;
				rd_vld_q <= 1'b0;
			end else if (cmd.sum_step) begin
				rd_vld_q <= rd_en;
				if (rd_en) begin
					idx_q <= idx_q + COUNT_BITS'(1);
				end
			end

			if (cmd.div_start) begin
				dcnt_q <= '0;
			end else if (cmd.div_step && (dcnt_q != DCW'(SW))) begin
				dcnt_q <= dcnt_q + DCW'(1);
			end
		end
	end

	// accumulator, divider and output payload
	always_ff @(posedge clk) begin
		if (cmd.sum_start) begin
			acc_q <= '0;
		end else if (cmd.sum_step && rd_vld_q) begin
			acc_q <= acc_q + rd_ext;
		end

		if (cmd.div_start) begin
			neg_q <= acc_q[SW-1];
			quo_q <= acc_q[SW-1] ? (~acc_q + SW'(1)) : acc_q;
			rem_q <= '0;
		end else if (cmd.div_step && (dcnt_q != DCW'(SW))) begin
			quo_q <= {quo_q[SW-2:0], rem_ge};
			rem_q <= rem_ge ? COUNT_BITS'(rem_shift - {1'b0, cnt_q})
			                : COUNT_BITS'(rem_shift);
		end

		if (cmd.load_out) begin
			avg_q  <= quo_signed[SAMPLE_BITS-1:0];
			vcnt_q <= cnt_q;
		end
	end

	assign sts.sum_done = (idx_q == cnt_q) && !rd_vld_q;
	assign sts.div_done = (dcnt_q == DCW'(SW));

	assign average     = avg_q;
	assign valid_count = vcnt_q;

endmodule

// ===== rtl/mavgw_ctrl.sv =====
module mavgw_ctrl
	import mavgw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_action,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// command decode per state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_action == ACTION_CLEAR) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.write     = 1'b1;
						cmd.sum_start = 1'b1;
					end
				end
			end
			ST_SUM: begin
				cmd.sum_step  = 1'b1;
				cmd.div_start = sts.sum_done;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_DONE: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && (in_action == ACTION_SAMPLE)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (sts.sum_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sts.div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/moving_average_warmup_top.sv =====
// boxcar moving average with warm-up over a ring store of MAX_WINDOW samples
// sample beat: result valid after a serial sum of count entries through the store
// read port, then a one bit per cycle divide; no new beat is taken until the result
// is loaded, and the next beat is taken in the cycle after that
// clear beat: no result; reset clears position, full flag, output valid and sets
// the window length to 15
module moving_average_warmup_top
	import mavgw_pkg::*;
#(
	parameter int unsigned MAX_WINDOW  = 16,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                  cfg_wen,
	input  logic [COUNT_BITS-1:0] cfg_wdata,   // window_length

	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // sample
	input  logic                                  s_tuser,   // action

	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// average, valid_count, zero fill
	output logic [((SAMPLE_BITS+COUNT_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int unsigned OUT_W = ((SAMPLE_BITS + COUNT_BITS + 7) / 8) * 8;

	dp_cmd_t                       cmd;
	dp_sts_t                       sts;
	logic signed [SAMPLE_BITS-1:0] average;
	logic [COUNT_BITS-1:0]         valid_count;

	// sequencing
	mavgw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// store, sum, divide and result register
	mavgw_datapath #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.sample      (s_tdata[SAMPLE_BITS-1:0]),
		.average     (average),
		.valid_count (valid_count)
	);

	// pack the result beat
	assign m_tdata = OUT_W'({valid_count, average});

endmodule

// ===== bench/tb_moving_average_warmup_top.sv =====
module tb_moving_average_warmup_top;
	import mavgw_pkg::*;

	localparam int unsigned MAX_WIN = 16;
	localparam int unsigned SMP_BITS = 16;
	localparam int SETTLE_CYCLES = 48;
	localparam int LONG_HOLD = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = 60;
	localparam int RANDOM_BEATS = 600;

	typedef enum logic [1:0] {
		STIM_BEAT,
		STIM_SET_LEN,
		STIM_DRAIN,
		STIM_HOLD_RX
	} stim_kind_t;

	typedef struct {
		stim_kind_t kind;
		logic action;
		logic [SMP_BITS-1:0] sample;
		logic [COUNT_BITS-1:0] len_val;
	} stim_t;

	typedef struct {
		logic [SMP_BITS-1:0] average;
		logic [COUNT_BITS-1:0] count;
	} mean_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [COUNT_BITS-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;   // sample
	logic s_tuser = ACTION_SAMPLE;   // action
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;   // average, valid_count, zero fill

	moving_average_warmup_top #(
		.MAX_WINDOW(MAX_WIN),
		.SAMPLE_BITS(SMP_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// pending stimulus and expected means
	stim_t stim_q[$];
	mean_t mean_due[$];
	int mismatches = 0;
	int beats_queued = 0;

	// predictor state
	logic signed [SMP_BITS-1:0] win_mem[MAX_WIN];
	logic [COUNT_BITS-1:0] win_len = LEN_RESET;
	int win_pos = 0;
	bit win_full = 1'b0;

	// driver and receiver state
	bit beat_taken = 1'b0;
	bit have_cur = 1'b0;
	bit drv_done = 1'b0;
	stim_t cur;
	int tx_gap = 0;
	int tx_calm = 0;
	int settle = 0;
	int rx_wait = 0;
	int rx_calm = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int idle_cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 50)
			$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// idle length: mostly none or short, a few long, with calm runs of no idling
	function automatic int pick_idle(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	// update the window and work out the mean a sample beat produces
	task automatic predict_mean(input logic act, input logic [SMP_BITS-1:0] smp);
		int eff;
		int cnt;
		int acc;
		mean_t res;
		eff = (win_len == 0) ? 1 : ((win_len > MAX_WIN) ? MAX_WIN : int'(win_len));
		if (act == ACTION_CLEAR) begin
			win_pos = 0;
			win_full = 1'b0;
			return;
		end
		if (win_pos >= eff)
			win_pos = 0;
		win_mem[win_pos] = signed'(smp);
		win_pos++;
		if (win_pos >= eff) begin
			win_pos = 0;
			win_full = 1'b1;
		end
		cnt = win_full ? eff : win_pos;
		acc = 0;
		for (int i = 0; i < cnt; i++)
			acc += win_mem[i];
		res.average = SMP_BITS'(acc / cnt);
		res.count = COUNT_BITS'(cnt);
		mean_due.push_back(res);
	endtask

	task automatic check_mean();
		mean_t e;
		if (mean_due.size() == 0) begin
			report_mismatch($sformatf("result %h with none due", m_tdata));
			return;
		end
		e = mean_due.pop_front();
		if (m_tdata[15:0] !== e.average)
			report_mismatch($sformatf("average %h, expected %h (count %0d)",
				m_tdata[15:0], e.average, e.count));
		if (m_tdata[20:16] !== e.count)
			report_mismatch($sformatf("valid_count %0d, expected %0d",
				m_tdata[20:16], e.count));
	endtask

	// stimulus builders
	task automatic push_beat(input logic act, input logic [SMP_BITS-1:0] smp);
		stim_t s;
		s.kind = STIM_BEAT;
		s.action = act;
		s.sample = smp;
		s.len_val = '0;
		stim_q.push_back(s);
		beats_queued++;
	endtask

	task automatic push_op(input stim_kind_t kind, input logic [COUNT_BITS-1:0] val);
		stim_t s;
		s.kind = kind;
		s.action = ACTION_SAMPLE;
		s.sample = '0;
		s.len_val = val;
		stim_q.push_back(s);
	endtask

	function automatic logic [SMP_BITS-1:0] pick_sample();
		logic [SMP_BITS-1:0] edges[5];
		edges = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000, 16'h0001};
		if ($urandom_range(0, 99) < 15)
			return edges[$urandom_range(0, 4)];
		return SMP_BITS'($urandom_range(0, 65535));
	endfunction

	// monitor: results, register writes, accepted beats and the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_mean();
			if (cfg_wen) begin
				win_len = cfg_wdata;
				win_pos = 0;
				win_full = 1'b0;
			end
			if (s_tvalid && s_tready) begin
				predict_mean(s_tuser, s_tdata);
				beat_taken = 1'b1;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no beat for %0d cycles", idle_cycles);
				$display("tb_moving_average_warmup_top: FAIL");
				$finish;
			end
		end
	end

	// driver: offers beats, pauses, and writes the window length when idle
	always @(negedge clk) begin
		logic nv;
		logic nw;
		nv = s_tvalid;
		nw = 1'b0;
		if (arst_n) begin
			if (beat_taken) begin
				nv = 1'b0;
				beat_taken = 1'b0;
			end
			if (!nv) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else begin
					if (!have_cur && stim_q.size() != 0) begin
						cur = stim_q.pop_front();
						have_cur = 1'b1;
						settle = 0;
					end
					if (have_cur) begin
						case (cur.kind)
						STIM_BEAT: begin
							nv = 1'b1;
							s_tdata <= cur.sample;
							s_tuser <= cur.action;
							have_cur = 1'b0;
							tx_gap = pick_idle(tx_calm);
						end
						STIM_DRAIN: begin
							if (mean_due.size() == 0)
								have_cur = 1'b0;
						end
						STIM_HOLD_RX: begin
							hold_req <= hold_req + 1;
							have_cur = 1'b0;
						end
						STIM_SET_LEN: begin
							// block must be idle, then let a clear finish
							if (mean_due.size() != 0) begin
								settle = 0;
							end else if (settle < SETTLE_CYCLES) begin
								settle++;
							end else begin
								nw = 1'b1;
								cfg_wdata <= cur.len_val;
								have_cur = 1'b0;
							end
						end
						default: have_cur = 1'b0;
						endcase
					end
				end
			end
			drv_done = !have_cur && stim_q.size() == 0 && !nv;
		end
		s_tvalid <= nv;
		cfg_wen <= nw;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		int n;
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			rx_wait = LONG_HOLD;
		end
		if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			n = pick_idle(rx_calm);
			if (n == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				rx_wait = n - 1;
			end
		end
	end

	initial begin
		logic d;
		int items;
		int r;
		logic [COUNT_BITS-1:0] len;

		foreach (win_mem[i])
			win_mem[i] = '0;

		// directed: warm-up at the reset length with extreme samples
		push_beat(ACTION_SAMPLE, 16'h7fff);
		push_beat(ACTION_SAMPLE, 16'h8000);
		push_beat(ACTION_SAMPLE, 16'hffff);
		push_beat(ACTION_SAMPLE, 16'h0001);
		// clear, then a negative sum that truncates toward zero
		push_beat(ACTION_CLEAR, 16'h0000);
		push_beat(ACTION_SAMPLE, 16'hffff);
		push_beat(ACTION_SAMPLE, 16'h0000);
		push_op(STIM_DRAIN, '0);
		// shortest window
		push_op(STIM_SET_LEN, 5'd1);
		push_beat(ACTION_SAMPLE, 16'h8000);
		push_beat(ACTION_SAMPLE, 16'h7fff);
		// zero length behaves as one
		push_op(STIM_SET_LEN, 5'd0);
		push_beat(ACTION_SAMPLE, 16'h1234);
		// two-entry window wraps and becomes full
		push_op(STIM_SET_LEN, 5'd2);
		push_beat(ACTION_SAMPLE, 16'h7fff);
		push_beat(ACTION_SAMPLE, 16'h7fff);
		push_beat(ACTION_SAMPLE, 16'h8000);
		push_beat(ACTION_CLEAR, 16'hffff);
		push_beat(ACTION_SAMPLE, 16'h0100);
		// oversized length saturates to the store depth
		push_op(STIM_SET_LEN, 5'd31);
		push_beat(ACTION_SAMPLE, 16'h8000);
		push_beat(ACTION_SAMPLE, 16'h8000);
		push_beat(ACTION_SAMPLE, 16'h0001);

		// random phases, each under one window length
		for (int ph = 0; beats_queued < RANDOM_BEATS + 20; ph++) begin
			case (ph)
			0: len = 5'd16;
			1: len = 5'd1;
			2: len = 5'd0;
			3: len = 5'd31;
			default: begin
				if ($urandom_range(0, 3) == 0)
					len = 5'd16;
				else
					len = COUNT_BITS'($urandom_range(0, 31));
			end
			endcase
			push_op(STIM_SET_LEN, len);
			items = $urandom_range(30, 70);
			for (int k = 0; k < items; k++) begin
				// long receiver hold-off while beats keep coming
				if (ph == 0 && k == 10)
					push_op(STIM_HOLD_RX, '0);
				r = $urandom_range(0, 99);
				if (r < 2)
					push_op(STIM_DRAIN, '0);
				if (r < 8)
					push_beat(ACTION_CLEAR, pick_sample());
				else
					push_beat(ACTION_SAMPLE, pick_sample());
			end
		end

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// driver done, then every mean delivered
		do begin
			@(posedge clk);
			d = drv_done;
			@(negedge clk);
		end while (!d || mean_due.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mean_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", mean_due.size()));
		if (mismatches == 0)
			$display("tb_moving_average_warmup_top: PASS");
		else
			$display("tb_moving_average_warmup_top: FAIL");
		$finish;
	end

endmodule
